@@ design/ptm_pkg.sv @@
// ----------------------------------------------------------------------------
// ptm_pkg
// Shared types and constants for the prescaled reload timer: request and
// result beat layouts, request codes, register map and control bit positions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ptm_pkg;

  localparam int DATA_W              = 32;
  localparam int COUNT_WIDTH_DEF     = 32;
  localparam int PRESCALE_WIDTH_DEF  = 16;

  // request types
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_WRITE = 2'd2;

  // register map
  localparam logic [2:0] REG_CTRL   = 3'd0;
  localparam logic [2:0] REG_IRQ_EN = 3'd1;
  localparam logic [2:0] REG_STATUS = 3'd2;
  localparam logic [2:0] REG_EVENT  = 3'd3;
  localparam logic [2:0] REG_COUNT  = 3'd4;
  localparam logic [2:0] REG_PSC    = 3'd5;
  localparam logic [2:0] REG_RELOAD = 3'd6;

  // control register bit positions
  localparam int CTRL_EN_BIT   = 0;
  localparam int CTRL_OPM_BIT  = 3;
  localparam int CTRL_DOWN_BIT = 4;
  localparam int CTRL_ARPE_BIT = 7;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [2:0]        reg_index;
    logic [DATA_W-1:0] write_data;
  } ptm_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              irq;
    logic              update_pulse;
  } ptm_rsp_t;

  typedef struct packed {
    logic en;
    logic opm;
    logic down;
    logic arpe;
  } ptm_ctrl_t;

endpackage

`default_nettype wire

@@ design/prescaled_reload_timer.sv @@
// ----------------------------------------------------------------------------
// prescaled_reload_timer
// General purpose timer with prescaler, auto-reload and update interrupt,
// driven by one tick or bus access per request beat.
// ----------------------------------------------------------------------------
//  channel | direction | beat       | handshake
//  in_     | input     | ptm_req_t  | in_valid / in_stall
//  out_    | output    | ptm_rsp_t  | out_valid / out_stall
//
//  One request beat per cycle while the output is not stalled; a taken request
//  passes through the request register, then the response register.
//  The combinational timer update between the two registers sets the rate.
//  Synchronous active-low reset clears control and counters, sets reload to ones.
//  A stalled response holds; the request register takes one more beat, then stalls the input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module prescaled_reload_timer
  import ptm_pkg::*;
#(
  parameter int COUNT_WIDTH    = COUNT_WIDTH_DEF,
  parameter int PRESCALE_WIDTH = PRESCALE_WIDTH_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire ptm_req_t in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output ptm_rsp_t      out_data
);

  logic                      s1_valid_r;
  ptm_req_t                  s1_r;
  logic                      out_valid_r;
  ptm_rsp_t                  out_r;
  logic                      advance;

  ptm_ctrl_t                 ctrl_r, ctrl_nxt;
  logic                      irq_en_r, irq_en_nxt;
  logic                      flag_r, flag_nxt;
  logic [COUNT_WIDTH-1:0]    cnt_r, cnt_nxt;
  logic [PRESCALE_WIDTH-1:0] psc_pre_r, psc_pre_nxt;
  logic [PRESCALE_WIDTH-1:0] psc_act_r, psc_act_nxt;
  logic [PRESCALE_WIDTH-1:0] psc_cnt_r, psc_cnt_nxt;
  logic [COUNT_WIDTH-1:0]    rld_pre_r, rld_pre_nxt;
  logic [COUNT_WIDTH-1:0]    rld_act_r, rld_act_nxt;
  ptm_rsp_t                  rsp_nxt;
  logic                      upd;
  logic                      wrap;

  assign advance   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    ctrl_nxt    = ctrl_r;
    irq_en_nxt  = irq_en_r;
    flag_nxt    = flag_r;
    cnt_nxt     = cnt_r;
    psc_pre_nxt = psc_pre_r;
    psc_act_nxt = psc_act_r;
    psc_cnt_nxt = psc_cnt_r;
    rld_pre_nxt = rld_pre_r;
    rld_act_nxt = rld_act_r;
    rsp_nxt     = '0;
    upd         = 1'b0;
    wrap        = 1'b0;

    case (s1_r.req_type)
      REQ_TICK: begin
        if (ctrl_r.en) begin
          if (psc_cnt_r >= psc_act_r) begin
            psc_cnt_nxt = '0;
            if (ctrl_r.down) begin
              wrap    = (cnt_r == '0);
              cnt_nxt = wrap ? rld_act_r : cnt_r - 1'b1;
            end else begin
              wrap    = (cnt_r >= rld_act_r);
              cnt_nxt = wrap ? '0 : cnt_r + 1'b1;
            end
            upd = wrap;
          end else begin
            psc_cnt_nxt = psc_cnt_r + 1'b1;
          end
        end
      end
      REQ_READ: begin
        case (s1_r.reg_index)
          REG_CTRL: begin
            rsp_nxt.read_data[CTRL_EN_BIT]   = ctrl_r.en;
            rsp_nxt.read_data[CTRL_OPM_BIT]  = ctrl_r.opm;
            rsp_nxt.read_data[CTRL_DOWN_BIT] = ctrl_r.down;
            rsp_nxt.read_data[CTRL_ARPE_BIT] = ctrl_r.arpe;
          end
          REG_IRQ_EN: rsp_nxt.read_data[0] = irq_en_r;
          REG_STATUS: rsp_nxt.read_data[0] = flag_r;
          REG_COUNT:  rsp_nxt.read_data = DATA_W'(cnt_r);
          REG_PSC:    rsp_nxt.read_data = DATA_W'(psc_pre_r);
          REG_RELOAD: rsp_nxt.read_data = DATA_W'(rld_pre_r);
          default:    rsp_nxt.read_data = '0;
        endcase
      end
      REQ_WRITE: begin
        case (s1_r.reg_index)
          REG_CTRL: begin
            ctrl_nxt.en   = s1_r.write_data[CTRL_EN_BIT];
            ctrl_nxt.opm  = s1_r.write_data[CTRL_OPM_BIT];
            ctrl_nxt.down = s1_r.write_data[CTRL_DOWN_BIT];
            ctrl_nxt.arpe = s1_r.write_data[CTRL_ARPE_BIT];
          end
          REG_IRQ_EN: irq_en_nxt = s1_r.write_data[0];
          REG_STATUS: flag_nxt = flag_r & s1_r.write_data[0];
          REG_EVENT: begin
            if (s1_r.write_data[0]) begin
              upd     = 1'b1;
              cnt_nxt = ctrl_r.down ? rld_pre_r : '0;
            end
          end
          REG_COUNT: cnt_nxt = s1_r.write_data[COUNT_WIDTH-1:0];
          REG_PSC:   psc_pre_nxt = s1_r.write_data[PRESCALE_WIDTH-1:0];
          REG_RELOAD: begin
            rld_pre_nxt = s1_r.write_data[COUNT_WIDTH-1:0];
            if (!ctrl_r.arpe) begin
              rld_act_nxt = s1_r.write_data[COUNT_WIDTH-1:0];
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase

    if (upd) begin
      flag_nxt    = 1'b1;
      psc_cnt_nxt = '0;
      psc_act_nxt = psc_pre_r;
      rld_act_nxt = rld_pre_r;
      if (ctrl_r.opm) begin
        ctrl_nxt.en = 1'b0;
      end
    end

    rsp_nxt.update_pulse = upd;
    rsp_nxt.irq          = flag_nxt & irq_en_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      ctrl_r      <= '0;
      irq_en_r    <= 1'b0;
      flag_r      <= 1'b0;
      cnt_r       <= '0;
      psc_pre_r   <= '0;
      psc_act_r   <= '0;
      psc_cnt_r   <= '0;
      rld_pre_r   <= '1;
      rld_act_r   <= '1;
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (advance) begin
        ctrl_r    <= ctrl_nxt;
        irq_en_r  <= irq_en_nxt;
        flag_r    <= flag_nxt;
        cnt_r     <= cnt_nxt;
        psc_pre_r <= psc_pre_nxt;
        psc_act_r <= psc_act_nxt;
        psc_cnt_r <= psc_cnt_nxt;
        rld_pre_r <= rld_pre_nxt;
        rld_act_r <= rld_act_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_r <= in_data;
    end
    if (advance) begin
      out_r <= rsp_nxt;
    end
  end

`ifndef SYNTH
  a_irq_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.irq) |-> (flag_r && irq_en_r))
    else $error("irq beat without flag and enable");

  a_pulse_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.update_pulse) |-> (flag_r && psc_cnt_r == '0))
    else $error("update beat without flag set and prescale cleared");

  a_psc_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    psc_cnt_r <= psc_act_r)
    else $error("prescale count above active prescaler");

  a_opm_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && upd && ctrl_r.opm) |=> !ctrl_r.en)
    else $error("one-pulse update left counter enabled");
`endif

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the prescaled reload timer. A shadow timer in the
// bench predicts every response beat from the request beats the block takes.
// A checker compares each response field by field. Directed tasks cover the
// reset values, register access, up counting and one-pulse down counting.
// Random traffic then runs under three idle mixes, with one long
// back-pressure stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import ptm_pkg::*;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  ptm_req_t in_data;
  logic     out_valid;
  logic     out_stall;
  ptm_rsp_t out_data;

  int send_idle_pct;
  int recv_idle_pct;
  bit long_hold_req;
  int hold_left;
  int fail_count;

  ptm_rsp_t expected_rsp_q[$];

  ptm_ctrl_t   tmr_ctrl;
  logic        tmr_irq_en;
  logic        tmr_upd_flag;
  logic [31:0] tmr_count;
  logic [15:0] tmr_psc_pre;
  logic [15:0] tmr_psc_act;
  logic [15:0] tmr_psc_cnt;
  logic [31:0] tmr_reload_pre;
  logic [31:0] tmr_reload_act;

  prescaled_reload_timer i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic void apply_update();
    tmr_upd_flag   = 1'b1;
    tmr_psc_cnt    = '0;
    tmr_psc_act    = tmr_psc_pre;
    tmr_reload_act = tmr_reload_pre;
    if (tmr_ctrl.opm) tmr_ctrl.en = 1'b0;
  endfunction

  function automatic ptm_rsp_t next_timer_response(input ptm_req_t req);
    ptm_rsp_t rsp;
    logic     wrap;
    rsp  = '0;
    wrap = 1'b0;
    case (req.req_type)
      REQ_TICK: begin
        if (tmr_ctrl.en) begin
          if (tmr_psc_cnt >= tmr_psc_act) begin
            tmr_psc_cnt = '0;
            if (tmr_ctrl.down) begin
              wrap      = (tmr_count == '0);
              tmr_count = wrap ? tmr_reload_act : tmr_count - 32'd1;
            end else begin
              wrap      = (tmr_count >= tmr_reload_act);
              tmr_count = wrap ? '0 : tmr_count + 32'd1;
            end
            if (wrap) begin
              apply_update();
              rsp.update_pulse = 1'b1;
            end
          end else begin
            tmr_psc_cnt = tmr_psc_cnt + 16'd1;
          end
        end
      end
      REQ_READ: begin
        case (req.reg_index)
          REG_CTRL: begin
            rsp.read_data[CTRL_EN_BIT]   = tmr_ctrl.en;
            rsp.read_data[CTRL_OPM_BIT]  = tmr_ctrl.opm;
            rsp.read_data[CTRL_DOWN_BIT] = tmr_ctrl.down;
            rsp.read_data[CTRL_ARPE_BIT] = tmr_ctrl.arpe;
          end
          REG_IRQ_EN: rsp.read_data = {31'd0, tmr_irq_en};
          REG_STATUS: rsp.read_data = {31'd0, tmr_upd_flag};
          REG_COUNT:  rsp.read_data = tmr_count;
          REG_PSC:    rsp.read_data = {16'd0, tmr_psc_pre};
          REG_RELOAD: rsp.read_data = tmr_reload_pre;
          default:    rsp.read_data = '0;
        endcase
      end
      REQ_WRITE: begin
        case (req.reg_index)
          REG_CTRL: begin
            tmr_ctrl.en   = req.write_data[CTRL_EN_BIT];
            tmr_ctrl.opm  = req.write_data[CTRL_OPM_BIT];
            tmr_ctrl.down = req.write_data[CTRL_DOWN_BIT];
            tmr_ctrl.arpe = req.write_data[CTRL_ARPE_BIT];
          end
          REG_IRQ_EN: tmr_irq_en = req.write_data[0];
          REG_STATUS: tmr_upd_flag = tmr_upd_flag & req.write_data[0];
          REG_EVENT: begin
            if (req.write_data[0]) begin
              apply_update();
              tmr_count        = tmr_ctrl.down ? tmr_reload_act : '0;
              rsp.update_pulse = 1'b1;
            end
          end
          REG_COUNT: tmr_count = req.write_data;
          REG_PSC:   tmr_psc_pre = req.write_data[15:0];
          REG_RELOAD: begin
            tmr_reload_pre = req.write_data;
            if (!tmr_ctrl.arpe) tmr_reload_act = tmr_reload_pre;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    rsp.irq = tmr_upd_flag & tmr_irq_en;
    return rsp;
  endfunction

  function automatic ptm_req_t make_req(input logic [1:0] kind, input logic [2:0] idx,
                                        input logic [31:0] data);
    ptm_req_t req;
    req.req_type   = kind;
    req.reg_index  = idx;
    req.write_data = data;
    return req;
  endfunction

  function automatic ptm_req_t rand_timer_req();
    ptm_req_t req;
    int       pick;
    pick           = $urandom_range(99);
    req.reg_index  = 3'($urandom_range(7));
    req.write_data = $urandom;
    if (pick < 55) begin
      req.req_type = REQ_TICK;
    end else if (pick < 70) begin
      req.req_type = REQ_READ;
    end else if (pick < 97) begin
      req.req_type = REQ_WRITE;
      case (req.reg_index)
        REG_CTRL: begin
          if ($urandom_range(3) != 0) req.write_data[CTRL_EN_BIT] = 1'b1;
          if ($urandom_range(3) != 0) req.write_data[CTRL_OPM_BIT] = 1'b0;
        end
        REG_COUNT:  if ($urandom_range(7) != 0) req.write_data = $urandom_range(20);
        REG_PSC:    if ($urandom_range(7) != 0) req.write_data = $urandom_range(3);
        REG_RELOAD: if ($urandom_range(7) != 0) req.write_data = $urandom_range(15);
        default: ;
      endcase
    end else begin
      req.req_type = 2'd3;
    end
    return req;
  endfunction

  task automatic send_beat(input ptm_req_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    expected_rsp_q.push_back(next_timer_response(req));
    @(negedge clk);
  endtask

  initial begin
    bit hold_done;
    hold_done = 1'b0;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = 80;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  initial begin
    ptm_rsp_t exp_rsp;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (expected_rsp_q.size() == 0) begin
          $error("response beat with none expected");
          fail_count++;
        end else begin
          exp_rsp = expected_rsp_q.pop_front();
          if (out_data.read_data !== exp_rsp.read_data) begin
            $error("read_data mismatch: expected %h actual %h",
                   exp_rsp.read_data, out_data.read_data);
            fail_count++;
          end
          if (out_data.irq !== exp_rsp.irq) begin
            $error("irq mismatch: expected %b actual %b", exp_rsp.irq, out_data.irq);
            fail_count++;
          end
          if (out_data.update_pulse !== exp_rsp.update_pulse) begin
            $error("update_pulse mismatch: expected %b actual %b",
                   exp_rsp.update_pulse, out_data.update_pulse);
            fail_count++;
          end
        end
      end
    end
  end

  task automatic test_reset_values();
    send_beat(make_req(REQ_READ, REG_CTRL, 32'h0));
    send_beat(make_req(REQ_READ, REG_COUNT, 32'h0));
    send_beat(make_req(REQ_READ, REG_RELOAD, 32'h0));
    send_beat(make_req(REQ_READ, REG_STATUS, 32'h0));
  endtask

  task automatic test_register_access();
    send_beat(make_req(REQ_WRITE, REG_CTRL, 32'hFFFF_FFFF));
    send_beat(make_req(REQ_READ, REG_CTRL, 32'h0));
    send_beat(make_req(REQ_WRITE, REG_IRQ_EN, 32'hFFFF_FFFF));
    send_beat(make_req(REQ_WRITE, REG_PSC, 32'hFFFF_FFFF));
    send_beat(make_req(REQ_READ, REG_PSC, 32'h0));
    send_beat(make_req(REQ_WRITE, REG_COUNT, 32'hFFFF_FFFF));
    send_beat(make_req(REQ_READ, REG_COUNT, 32'hFFFF_FFFF));
    send_beat(make_req(REQ_WRITE, 3'd7, 32'hFFFF_FFFF));
    send_beat(make_req(2'd3, 3'd7, 32'hFFFF_FFFF));
  endtask

  task automatic test_up_count();
    send_beat(make_req(REQ_WRITE, REG_PSC, 32'd1));
    send_beat(make_req(REQ_WRITE, REG_RELOAD, 32'd2));
    send_beat(make_req(REQ_WRITE, REG_EVENT, 32'd1));
    send_beat(make_req(REQ_WRITE, REG_CTRL, 32'd1 << CTRL_EN_BIT));
    send_beat(make_req(REQ_WRITE, REG_COUNT, 32'd7));
    repeat (2) send_beat(make_req(REQ_TICK, REG_CTRL, $urandom));
    send_beat(make_req(REQ_WRITE, REG_STATUS, 32'd1));
    send_beat(make_req(REQ_WRITE, REG_STATUS, 32'd0));
    send_beat(make_req(REQ_READ, REG_STATUS, 32'd0));
  endtask

  task automatic test_down_one_pulse();
    send_beat(make_req(REQ_WRITE, REG_CTRL,
                       (32'd1 << CTRL_EN_BIT) | (32'd1 << CTRL_OPM_BIT) |
                       (32'd1 << CTRL_DOWN_BIT)));
    repeat (4) send_beat(make_req(REQ_TICK, REG_CTRL, $urandom));
    send_beat(make_req(REQ_READ, REG_CTRL, 32'd0));
  endtask

  task automatic test_back_pressure();
    long_hold_req = 1'b1;
    repeat (30) send_beat(rand_timer_req());
  endtask

  task automatic test_random(input int n_beats);
    repeat (n_beats) send_beat(rand_timer_req());
  endtask

  initial begin
    int wait_cycles;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    long_hold_req = 1'b0;
    fail_count    = 0;
    send_idle_pct = 27;
    recv_idle_pct = 82;
    tmr_ctrl       = '0;
    tmr_irq_en     = 1'b0;
    tmr_upd_flag   = 1'b0;
    tmr_count      = '0;
    tmr_psc_pre    = '0;
    tmr_psc_act    = '0;
    tmr_psc_cnt    = '0;
    tmr_reload_pre = '1;
    tmr_reload_act = '1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_values();
    test_register_access();
    test_up_count();
    test_down_one_pulse();
    test_back_pressure();
    test_random(130);
    send_idle_pct = 82;
    recv_idle_pct = 27;
    test_random(130);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(130);
    in_valid <= 1'b0;

    wait_cycles = 0;
    while (expected_rsp_q.size() != 0 && wait_cycles < 5000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (20) @(posedge clk);
    if (expected_rsp_q.size() != 0) begin
      $error("%0d response beats never arrived", expected_rsp_q.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
